// ===== design/dhtis_pkg.sv =====
// Shared types and constants for the double hashing table block.
`default_nettype none

package dhtis_pkg;

    // Default geometry of the table.
    localparam int DEF_TABLE_SIZE = 16;
    localparam int DEF_MAX_PROBES = 16;

    // Key and beat layout.
    localparam int KEY_W        = 31;
    localparam int KEY_PAD      = 32;
    localparam int STATUS_W     = 3;
    localparam int SLOT_OUT_W   = 4;
    localparam int STEPS_W      = 5;
    localparam int MAXS_W       = 5;
    localparam int TDATA_PAD    = 2;
    localparam int IN_TDATA_W   = KEY_PAD;
    localparam int OUT_TDATA_W  = SLOT_OUT_W + STEPS_W + MAXS_W + TDATA_PAD;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FOUND    = 3'd1,
        ST_MISSING  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOROOM   = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_HASH  = 6'b001000,
        S_PROBE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== design/double_hash_table_insert_search.sv =====
// Open-addressing hash table with double hashing: insert and search of 31-bit keys.
// An item passes through the key residue, hash and probe states, the probes reading the
// table RAM one probe ahead of each check; an insert into a full table skips the probes.
// Its result is then registered for output, and a new item is accepted only after that.
// Reset: synchronous, active low; a clearing pass empties every slot, during which
// no beat is accepted.
`default_nettype none

module double_hash_table_insert_search
    import dhtis_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int MAX_PROBES = DEF_MAX_PROBES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [30:0] key, [31] zero
    input  wire logic                   i_s_axis_tuser,   // [0] op
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,   // [3:0] slot, [8:4] steps,
                                                          // [13:9] max_steps_out, [15:14] zero
    output logic [STATUS_W-1:0]         o_m_axis_tuser    // [2:0] status
);

    localparam int SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int P_W    = $clog2(MAX_PROBES + 2);
    localparam int FREE_W = $clog2(TABLE_SIZE + 1);
    localparam int MEM_W  = KEY_W + 1;
    localparam int PROD_W = 2 * KEY_W + 1;
    localparam int RS     = KEY_W + $clog2(TABLE_SIZE);

    localparam logic [SLOT_W:0]        TSIZE     = (SLOT_W+1)'(TABLE_SIZE);
    localparam logic [SLOT_W:0]        TWO       = (SLOT_W+1)'(2);
    localparam logic [SLOT_W-1:0]      LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [P_W-1:0]         LAST_INS  = P_W'(MAX_PROBES - 1);
    localparam logic [P_W-1:0]         MAX_P     = P_W'(MAX_PROBES);
    localparam logic [FREE_W-1:0]      FULL_FREE = FREE_W'(TABLE_SIZE);
    // Rounded-up reciprocal; (k * RECIP) >> RS is the exact quotient for every 31-bit key.
    localparam logic [KEY_W:0]         RECIP     =
        (KEY_W+1)'(((64'd1 << RS) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

    // (a + b) mod TABLE_SIZE for a below the size and b at most the size.
    function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W:0]   b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + b;
        if (s >= TSIZE) begin
            s = s - TSIZE;
        end
        return s[SLOT_W-1:0];
    endfunction

    // Table RAM: bit KEY_W is the used flag, the rest the key.
    logic [MEM_W-1:0] mem [TABLE_SIZE];
    logic [MEM_W-1:0] r_rd_data;

    t_state              r_state;
    t_op                 r_op;
    logic [KEY_W-1:0]    r_key;
    logic [PROD_W-1:0]   r_prod;
    logic [SLOT_W-1:0]   r_rem;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_stride;
    logic [P_W-1:0]      r_p;
    logic [P_W-1:0]      r_last;
    logic                r_iss;
    logic                r_chk;
    logic [P_W-1:0]      r_chk_p;
    logic [SLOT_W-1:0]   r_chk_slot;
    logic [FREE_W-1:0]   r_free;
    logic [P_W-1:0]      r_max;
    logic [SLOT_W-1:0]   r_clr;
    t_status             r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [P_W-1:0]      r_res_steps;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_tuser;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    logic [SLOT_W-1:0] t2, t3, t4, t7, hash_base, hash_stride;
    logic [SLOT_W-1:0] quot_lo, key_rem;
    logic              rd_used, rd_match, chk_hit, chk_end, ins_we, mem_we, rd_en;
    logic [SLOT_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [P_W-1:0]    chk_p1, n_max;

    // The remainder is below 2^SLOT_W, so only the low bits of k - q*TABLE_SIZE are needed.
    always_comb begin
        quot_lo = r_prod[RS +: SLOT_W];
        key_rem = r_key[SLOT_W-1:0] - SLOT_W'({1'b0, quot_lo} * TSIZE);
    end

    // Base (3k+2) and stride (7k+2), both reduced, from the key residue.
    always_comb begin
        t2          = add_mod(r_rem, {1'b0, r_rem});
        t3          = add_mod(t2, {1'b0, r_rem});
        t4          = add_mod(t2, {1'b0, t2});
        t7          = add_mod(t4, {1'b0, t3});
        hash_base   = add_mod(t3, TWO);
        hash_stride = add_mod(t7, TWO);
    end

    always_comb begin
        rd_used  = r_rd_data[KEY_W];
        rd_match = rd_used && (r_rd_data[KEY_W-1:0] == r_key);
        chk_hit  = r_chk && ((r_op == OP_INSERT) ? !rd_used : rd_match);
        chk_end  = r_chk && !chk_hit && (r_chk_p == r_last);
        ins_we   = (r_state == S_PROBE) && chk_hit && (r_op == OP_INSERT);
        rd_en    = (r_state == S_PROBE) && r_iss;
        chk_p1   = r_chk_p + 1'b1;
        n_max    = (r_max < chk_p1) ? chk_p1 : r_max;
        mem_we   = (r_state == S_CLEAR) || ins_we;
        if (r_state == S_CLEAR) begin
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_waddr = r_chk_slot;
            mem_wdata = {1'b1, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= FULL_FREE;
            r_max       <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_iss       <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= t_op'(i_s_axis_tuser);
                        r_key   <= i_s_axis_tdata[KEY_W-1:0];
                        r_prod  <= PROD_W'(i_s_axis_tdata[KEY_W-1:0]) * PROD_W'(RECIP);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem   <= key_rem;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    r_slot   <= hash_base;
                    r_stride <= hash_stride;
                    r_p      <= '0;
                    r_chk    <= 1'b0;
                    r_iss    <= 1'b1;
                    if (r_op == OP_INSERT) begin
                        r_last <= LAST_INS;
                        if (r_free == '0) begin
                            r_res_status <= ST_FULL;
                            r_res_slot   <= '0;
                            r_res_steps  <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end else begin
                        r_last  <= r_max;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // Reads run one probe ahead of the check of the returned word.
                    r_chk      <= r_iss;
                    r_chk_p    <= r_p;
                    r_chk_slot <= r_slot;
                    if (r_iss) begin
                        r_p    <= r_p + 1'b1;
                        r_slot <= add_mod(r_slot, {1'b0, r_stride});
                        r_iss  <= (r_p != r_last);
                    end
                    if (chk_hit) begin
                        r_chk      <= 1'b0;
                        r_iss      <= 1'b0;
                        r_state    <= S_DONE;
                        r_res_slot <= r_chk_slot;
                        if (r_op == OP_INSERT) begin
                            r_res_status <= ST_INSERTED;
                            r_res_steps  <= '0;
                            r_free       <= r_free - 1'b1;
                            r_max        <= n_max;
                        end else begin
                            r_res_status <= ST_FOUND;
                            r_res_steps  <= chk_p1;
                        end
                    end else if (chk_end) begin
                        r_chk      <= 1'b0;
                        r_iss      <= 1'b0;
                        r_state    <= S_DONE;
                        r_res_slot <= '0;
                        if (r_op == OP_INSERT) begin
                            r_res_status <= ST_NOROOM;
                            r_res_steps  <= '0;
                        end else begin
                            r_res_status <= ST_MISSING;
                            r_res_steps  <= r_max + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_tuser <= r_res_status;
                        r_out_tdata <= {{TDATA_PAD{1'b0}}, MAXS_W'(r_max),
                                        STEPS_W'(r_res_steps), SLOT_OUT_W'(r_res_slot)};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    a_free_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_we |=> (r_free == $past(r_free) - 1'b1))
        else $error("free count did not drop after an insert write");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FULL_FREE)
        else $error("free count above table size");

    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max <= MAX_P)
        else $error("recorded step maximum above probe bound");

    a_ins_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_res_status == ST_INSERTED)) |-> (r_max != '0))
        else $error("insert finished with zero step maximum");

endmodule

`default_nettype wire
